>>> sv/ltrf_pkg.sv
`timescale 1ns / 1ps
package ltrf_pkg;
    localparam int TARGET_COUNT = 8;
    localparam int IDX_W = 3;
    localparam logic [22:0] T_SEED_US   = 23'd100000;
    localparam logic [22:0] T_FILTER_US = 23'd3000000;
    localparam logic [22:0] T_MAX_US    = 23'd5000000;
    localparam logic [22:0] ELAPSED_MAX = 23'd8388607;
    localparam logic [19:0] PERIOD_RESET = 20'd20000;

    localparam logic signed [17:0] C_AA = 18'sd7078;
    localparam logic signed [17:0] C_AB = 18'sd5692;
    localparam logic signed [17:0] C_BB = 18'sd15003;
    localparam logic signed [17:0] C_AR = 18'sd1982;
    localparam logic signed [17:0] C_BR = 18'sd482;
    localparam logic signed [17:0] C_OA = 18'sd8166;
    localparam logic signed [17:0] C_OB = 18'sd45027;
    localparam logic signed [17:0] C_OR = 18'sd690;

    // limit steps: round(p * k / 10000) == floor((p * k/16 + 312) / 625)
    localparam logic signed [17:0] STEP_R_MUL = 18'sd136;
    localparam logic signed [17:0] STEP_T_MUL = 18'sd48;
    localparam logic [27:0] STEP_ROUND = 28'd312;
    // ceil(2^36 / 625), exact for numerators below 2^28
    localparam logic [26:0] STEP_RECIP = 27'd109951163;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    // round half up from Q8 and saturate to 16 bits
    function automatic logic [15:0] out16(input logic signed [31:0] q8);
        logic signed [32:0] v;
        logic signed [24:0] w;
        v = {q8[31], q8} + 33'sd128;
        w = v[32:8];
        if (w > 25'sd32767)
            return 16'h7fff;
        else if (w < -25'sd32768)
            return 16'h8000;
        else
            return w[15:0];
    endfunction
endpackage

>>> sv/ltrf_mac.sv
`timescale 1ns / 1ps
// Shared multiply-accumulate: one 18x32 product per cycle, registered, then summed.
module ltrf_mac
(
    input  logic               clk,
    input  logic               clear,
    input  logic               valid,
    input  logic signed [31:0] a,
    input  logic signed [17:0] b,
    output logic signed [63:0] acc
);
    logic signed [49:0] prod_reg;
    logic               pvalid_reg;
    logic signed [63:0] acc_reg;

    always_ff @(posedge clk)
    begin
        prod_reg   <= a * b;
        pvalid_reg <= valid;
        if (clear)
            acc_reg <= '0;
        else if (pvalid_reg)
            acc_reg <= acc_reg + 64'(prod_reg);
    end

    assign acc = acc_reg;
endmodule

>>> sv/lidar_target_range_filter_core.sv
`timescale 1ns / 1ps
// Channel   Dir  Payload
// s_axis    in   tdata[2:0] target_index, [18:3] range_cm, [34:19] rate_cm_s
// m_axis    out  tdata[15:0] long_pos_cm, [31:16] long_rate_cm_s, [35:32] target_number
// cfg       in   cfg_wdata = sample_period_us, written when cfg_we
// A target item that does not close a frame passes through S_SCAN and returns to S_IDLE.
// The closing item uses one shared multiplier for two limit-step products, each then
// scaled by a separate reciprocal multiply, and nine filter products, each registered
// before accumulation. Reset clears control state, filter state and the output valid.
// Reset loads the default sample period; a waiting result does not block input, but the
// next closing item holds in its last cycle until the result register is free.
module lidar_target_range_filter_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // target_index, range_cm, rate_cm_s
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // long_pos_cm, long_rate_cm_s, target_number
    input  logic        cfg_we,
    input  logic [19:0] cfg_wdata
);
    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_STEP, S_STEPW, S_LIM, S_X0, S_X0W, S_X1, S_X1W,
        S_Y, S_YW, S_OUT
    } state_t;

    state_t state_reg;
    logic [19:0] period_reg;
    logic [22:0] elapsed_reg, t_reg;
    logic signed [31:0] raw_range_reg, prev_raw_reg, held_range_reg, raw_rate_reg;
    logic signed [31:0] held_rate_reg, fa_reg, fb_reg, rq_reg;
    logic [2:0]  chosen_reg, idx_reg;
    logic signed [15:0] scan_rate_reg, rt_reg;
    logic [1:0]  k_reg;
    logic signed [31:0] step_r_reg, step_t_reg;
    logic signed [63:0] x0_reg;
    logic [39:0] mdata_reg;
    logic        mvalid_reg;

    logic        mac_clear, mac_valid;
    logic signed [31:0] mac_a;
    logic signed [17:0] mac_b;
    logic signed [63:0] mac_acc;

    ltrf_mac u_mac (.clk(clk), .clear(mac_clear), .valid(mac_valid),
                    .a(mac_a), .b(mac_b), .acc(mac_acc));

    logic [2:0]  in_idx;
    logic signed [15:0] in_r, in_rt, wr_r;
    logic [23:0] t_sum;
    logic [22:0] t_sat;
    assign in_idx = s_axis_tdata[2:0];
    assign in_r   = s_axis_tdata[18:3];
    assign in_rt  = s_axis_tdata[34:19];
    assign wr_r   = (in_r > 16'sd15000) ? in_r - 16'sd16256 : in_r;
    assign t_sum  = {1'b0, elapsed_reg} + {4'b0, period_reg};
    assign t_sat  = t_sum[23] ? ltrf_pkg::ELAPSED_MAX : t_sum[22:0];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata  = mdata_reg;

    function automatic logic signed [31:0] lim(input logic signed [31:0] o,
        input logic signed [31:0] tg, input logic signed [31:0] s);
        logic signed [33:0] up, dn;
        up = 34'(o) + 34'(s);
        dn = 34'(o) - 34'(s);
        if (34'(tg) > up)
            return ltrf_pkg::sat32(64'(up));
        else if (34'(tg) < dn)
            return ltrf_pkg::sat32(64'(dn));
        else
            return tg;
    endfunction

    // round_shift by 14 of an accumulated sum
    function automatic logic signed [63:0] rs14(input logic signed [63:0] v);
        logic signed [63:0] w;
        w = v + 64'sd8192;
        return w >>> 14;
    endfunction

    // multiplier sequencing: coefficient and operand by phase, for limit steps and filter
    always_comb
    begin
        mac_clear = 1'b0;
        mac_valid = 1'b0;
        mac_a = '0;
        mac_b = '0;
        case (state_reg)
            S_X0:
            begin
                mac_valid = 1'b1;
                case (k_reg)
                    2'd0: begin mac_a = fa_reg; mac_b = ltrf_pkg::C_AA; end
                    2'd1: begin mac_a = fb_reg; mac_b = -ltrf_pkg::C_AB; end
                    default: begin mac_a = held_range_reg; mac_b = ltrf_pkg::C_AR; end
                endcase
            end
            S_X1:
            begin
                mac_valid = 1'b1;
                case (k_reg)
                    2'd0: begin mac_a = fa_reg; mac_b = ltrf_pkg::C_AB; end
                    2'd1: begin mac_a = fb_reg; mac_b = ltrf_pkg::C_BB; end
                    default: begin mac_a = held_range_reg; mac_b = ltrf_pkg::C_BR; end
                endcase
            end
            S_Y:
            begin
                mac_valid = 1'b1;
                case (k_reg)
                    2'd0: begin mac_a = fa_reg; mac_b = ltrf_pkg::C_OA; end
                    2'd1: begin mac_a = fb_reg; mac_b = ltrf_pkg::C_OB; end
                    default: begin mac_a = held_range_reg; mac_b = ltrf_pkg::C_OR; end
                endcase
            end
            S_STEP:
            begin
                mac_valid = 1'b1;
                mac_a = {12'b0, period_reg};
                mac_b = (k_reg == 2'd0) ? ltrf_pkg::STEP_R_MUL : ltrf_pkg::STEP_T_MUL;
            end
            // sum is read in the last wait cycle, so clear it on that edge
            S_X0W, S_X1W:
                mac_clear = (k_reg == 2'd1);
            S_STEPW, S_YW, S_OUT:
                mac_clear = 1'b0;
            default:
                mac_clear = 1'b1;
        endcase
    end

    logic signed [33:0] d;
    logic [33:0] ad;
    logic jump;
    logic [27:0] step_n;
    logic [54:0] step_q;
    logic signed [31:0] stepnum;
    always_comb
    begin
        d = 34'(raw_range_reg) - 34'(prev_raw_reg);
        ad = d[33] ? 34'(-d) : 34'(d);
        jump = ({7'b0, ad} * 41'd125) > ({21'b0, period_reg} * 41'd224);
        step_n = mac_acc[27:0] + ltrf_pkg::STEP_ROUND;
        step_q = 55'(step_n) * 55'(ltrf_pkg::STEP_RECIP);
        stepnum = 32'(step_q[54:36]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            period_reg <= ltrf_pkg::PERIOD_RESET;
            elapsed_reg <= '0;
            t_reg <= '0;
            raw_range_reg <= '0; prev_raw_reg <= '0; held_range_reg <= '0;
            raw_rate_reg <= '0; held_rate_reg <= '0;
            fa_reg <= '0; fb_reg <= '0;
            chosen_reg <= '0; scan_rate_reg <= '0;
            mvalid_reg <= 1'b0;
            k_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                period_reg <= cfg_wdata;
            if (mvalid_reg && m_axis_tready)
                mvalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        idx_reg <= in_idx;
                        rq_reg  <= 32'(wr_r) <<< 8;
                        rt_reg  <= in_rt;
                        t_reg   <= t_sat;
                        state_reg <= S_SCAN;
                    end
                S_SCAN:
                begin
                    logic [2:0] ch;
                    ch = chosen_reg;
                    if (t_reg >= ltrf_pkg::T_SEED_US && t_reg < ltrf_pkg::T_MAX_US)
                    begin
                        if (rq_reg > 32'sd25600 && rq_reg < 32'sd2560000)
                        begin
                            raw_range_reg <= rq_reg;
                            ch = idx_reg;
                        end
                    end
                    else if (t_reg >= ltrf_pkg::T_MAX_US)
                    begin
                        if (rq_reg >= raw_range_reg)
                        begin
                            raw_range_reg <= rq_reg;
                            ch = idx_reg;
                        end
                    end
                    chosen_reg <= ch;
                    if (t_reg >= ltrf_pkg::T_SEED_US && ch == idx_reg)
                        scan_rate_reg <= rt_reg;
                    if (idx_reg == 3'(ltrf_pkg::TARGET_COUNT - 1))
                    begin
                        k_reg <= '0;
                        state_reg <= S_STEP;
                    end
                    else
                        state_reg <= S_IDLE;
                end
                S_STEP:
                    state_reg <= S_STEPW;
                S_STEPW:
                    state_reg <= S_LIM;
                S_LIM:
                begin
                    if (k_reg == 2'd0)
                    begin
                        step_r_reg <= stepnum;
                        k_reg <= 2'd1;
                        state_reg <= S_STEP;
                    end
                    else if (k_reg == 2'd1)
                    begin
                        step_t_reg <= stepnum;
                        k_reg <= 2'd2;
                    end
                    else
                    begin
                        logic signed [31:0] hr, rr, hrt;
                        elapsed_reg <= t_reg;
                        hr = held_range_reg;
                        hrt = held_rate_reg;
                        rr = raw_rate_reg;
                        if (t_reg < ltrf_pkg::T_SEED_US)
                        begin
                            hr = raw_range_reg;
                            hrt = raw_rate_reg;
                        end
                        else
                            rr = 32'(scan_rate_reg) <<< 8;
                        raw_rate_reg <= rr;
                        prev_raw_reg <= raw_range_reg;
                        if (!jump)
                            hr = lim(hr, raw_range_reg, step_r_reg);
                        held_range_reg <= hr;
                        held_rate_reg <= lim(hrt, rr, step_t_reg);
                        k_reg <= '0;
                        state_reg <= S_X0;
                    end
                end
                S_X0, S_X1, S_Y:
                begin
                    if (k_reg == 2'd2)
                    begin
                        k_reg <= '0;
                        state_reg <= (state_reg == S_X0) ? S_X0W :
                                     (state_reg == S_X1) ? S_X1W : S_YW;
                    end
                    else
                        k_reg <= k_reg + 2'd1;
                end
                S_X0W:
                    if (k_reg == 2'd1)
                    begin
                        x0_reg <= rs14(mac_acc);
                        k_reg <= '0;
                        state_reg <= S_X1;
                    end
                    else
                        k_reg <= k_reg + 2'd1;
                S_X1W:
                    if (k_reg == 2'd1)
                    begin
                        fa_reg <= ltrf_pkg::sat32(x0_reg);
                        fb_reg <= ltrf_pkg::sat32(rs14(mac_acc));
                        k_reg <= '0;
                        state_reg <= S_Y;
                    end
                    else
                        k_reg <= k_reg + 2'd1;
                S_YW:
                    if (k_reg == 2'd1)
                    begin
                        k_reg <= '0;
                        state_reg <= S_OUT;
                    end
                    else
                        k_reg <= k_reg + 2'd1;
                S_OUT:
                begin
                    logic signed [63:0] y;
                    logic signed [31:0] ov;
                    y = rs14(mac_acc);
                    ov = (t_reg < ltrf_pkg::T_FILTER_US) ? held_range_reg
                         : ((y > 64'sd2147483647) ? 32'sh7fffffff
                         : (y < -64'sd2147483648) ? 32'sh80000000 : y[31:0]);
                    // wait here until the previous result has left
                    if (!mvalid_reg)
                    begin
                        mdata_reg <= {4'b0, 4'({1'b0, chosen_reg} + 4'd1),
                                      ltrf_pkg::out16(held_rate_reg),
                                      ltrf_pkg::out16(ov)};
                        mvalid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (state_reg == S_IDLE)) else $error("ready outside idle");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (mvalid_reg && !m_axis_tready) |=> mvalid_reg) else $error("result dropped");
    a_tn_range: assert property (@(posedge clk) disable iff (!rst_n)
        mvalid_reg |-> (mdata_reg[35:32] != 4'd0)) else $error("bad target number");
endmodule
